// ===== rtl/csrs_pkg.sv =====
// ----------------------------------------------------------------------------
// csrs_pkg: shared types and constants for the chunk slice resend sender
// Slot table geometry, op and result codes, payload structs.
// ----------------------------------------------------------------------------
package csrs_pkg;

  localparam int SliceBytes = 1024;
  localparam int MaxSlices  = 64;
  localparam int MaxChunks  = 8;
  localparam int MaxRetries = 10;
  localparam int RunLimit   = 61;
  localparam int SlotW      = 3;
  localparam int SliceW     = 6;
  localparam int SbW        = 10;   // log2(SliceBytes)
  localparam logic [31:0] RateReset = 32'(1024 * 1024 / 8);
  localparam logic [32:0] DebtMax   = 33'h1_FFFF_FFFF;

  typedef enum logic [1:0] {
    OP_SUBMIT = 2'd0,
    OP_ACK    = 2'd1,
    OP_TICK   = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    K_SEND     = 3'd0,
    K_ACCEPT   = 3'd1,
    K_REJECT   = 3'd2,
    K_GIVEUP   = 3'd3,
    K_COMPLETE = 3'd4,
    K_TICKDONE = 3'd5,
    K_ACKDONE  = 3'd6
  } kind_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [16:0] chunk_size;
    logic [15:0] resend_ms;
    logic [15:0] elapsed_ms;
    logic [31:0] now_ms;
    logic [15:0] ack_chunk_id;
    logic [6:0]  ack_num_slices;
    logic [63:0] ack_bitmap;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] chunk_id;
    logic [5:0]  slice_index;
    logic [6:0]  num_slices;
    logic [10:0] slice_bytes;
    logic [15:0] byte_offset;
    logic [2:0]  slot;
    logic        last;
  } out_item_t;

  // per-slot descriptor, kept in the slot memory
  typedef struct packed {
    logic [15:0] chunk_id;
    logic [16:0] size;
    logic [6:0]  slices;
    logic [5:0]  cursor;
    logic [63:0] acked;
    logic [6:0]  acked_count;
    logic [15:0] resend;
    logic [3:0]  retries;
  } slot_ent_t;

endpackage

// ===== rtl/csrs_if.sv =====
// ----------------------------------------------------------------------------
// csrs_in_if / csrs_out_if: valid/ready channels
// Carry one input item or one result item per beat.
// ----------------------------------------------------------------------------
interface csrs_in_if;
  import csrs_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface csrs_out_if;
  import csrs_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/csrs_rate.sv =====
// ----------------------------------------------------------------------------
// csrs_rate: tick budget
// floor(rate*elapsed/1000)+1: 32x16 multiply, then a
// multiply by a reciprocal of 1000 with one correction step.
// ----------------------------------------------------------------------------
module csrs_rate import csrs_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] rate,
  input  logic [15:0] elapsed,
  output logic        done,
  output logic [38:0] budget
);
  // M = ceil(2^58/1000); exact for products below 2^48
  localparam logic [48:0] Recip = 49'd288230376151712;
  logic [47:0] prod;
  logic [3:0]  phase;
  logic [96:0] acc;
  logic [38:0] q;
  logic [47:0] rem;

  // reciprocal product split into 4 partial products of 12 bits
  logic [11:0] pdig;
  assign pdig = prod[12*phase[1:0] +: 12];

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (phase)
        4'd0: if (start) begin
          prod  <= 48'(rate) * 48'(elapsed);
          acc   <= '0;
          phase <= 4'd8;
        end
        4'd8, 4'd9, 4'd10, 4'd11: begin
          acc   <= acc + ({36'd0, 61'(pdig) * 61'(Recip)} << (12 * phase[1:0]));
          phase <= (phase == 4'd11) ? 4'd12 : phase + 4'd1;
        end
        4'd12: begin
          q     <= 39'(acc >> 58);
          phase <= 4'd13;
        end
        4'd13: begin
          rem   <= prod - 48'(q) * 48'd1000;
          phase <= 4'd14;
        end
        4'd14: begin
          budget <= ((rem >= 48'd1000) ? q + 39'd1 : q) + 39'd1;
          done   <= 1'b1;
          phase  <= 4'd0;
        end
        default: phase <= 4'd0;
      endcase
    end
  end
endmodule

// ===== rtl/csrs_ctrl.sv =====
// ----------------------------------------------------------------------------
// csrs_ctrl: op sequencer
// Reads slot descriptors and last-send times from two memories, modifies and
// writes back; emits results through a one-entry output register.
// ----------------------------------------------------------------------------
module csrs_ctrl import csrs_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [31:0] cfg_data,
  csrs_in_if.sink     in_ch,
  csrs_out_if.source  out_ch
);
  typedef enum logic [4:0] {
    S_IDLE, S_SUB_CLR, S_ACK_RD, S_ACK_W, S_ACK_BITS, S_ACK_END,
    S_TK_BUD, S_TK_PASS, S_TK_RD, S_TK_W, S_TK_LW, S_TK_EVAL, S_TK_NEXT,
    S_TK_END, S_EMIT
  } st_t;

  st_t         st, st_ret;
  logic [31:0] rate;
  logic [32:0] debt;
  logic [15:0] next_id;
  logic [MaxChunks-1:0] valid;
  in_item_t    it;

  // slot descriptor memory
  slot_ent_t   smem [MaxChunks];
  slot_ent_t   srd;
  logic [SlotW-1:0] sraddr;
  logic        swe;
  logic [SlotW-1:0] swaddr;
  slot_ent_t   swdata;
  // last-send memory
  logic [31:0] lmem [MaxChunks*MaxSlices];
  logic [31:0] lrd;
  logic [SlotW+SliceW-1:0] lraddr;
  logic        lwe;
  logic [SlotW+SliceW-1:0] lwaddr;
  logic [31:0] lwdata;

  always_ff @(posedge clk) begin
    if (swe) smem[swaddr] <= swdata;
    srd <= smem[sraddr];
    if (lwe) lmem[lwaddr] <= lwdata;
    lrd <= lmem[lraddr];
  end

  logic [SlotW-1:0] s;
  logic [SliceW:0]  idx;
  slot_ent_t   ent;
  logic [6:0]  n;
  logic [38:0] budget;
  logic [38:0] sent;
  logic        progress;
  logic        rstart, rdone;
  logic [38:0] rbudget;
  out_item_t   obuf;
  logic        ovalid;

  csrs_rate u_rate (
    .clk(clk), .rst(rst), .start(rstart), .rate(rate),
    .elapsed(it.elapsed_ms), .done(rdone), .budget(rbudget)
  );

  // free-slot search
  logic [SlotW-1:0] free_s;
  logic             free_any;
  always_comb begin
    free_s = '0;
    free_any = 1'b0;
    for (int i = MaxChunks - 1; i >= 0; i--) begin
      if (!valid[i]) begin
        free_s = SlotW'(i);
        free_any = 1'b1;
      end
    end
  end

  logic [6:0] sub_slices;
  assign sub_slices = 7'((it.chunk_size + 17'(SliceBytes - 1)) >> SbW);

  logic [5:0]  cur;
  logic [10:0] sb;
  logic        is_last;
  logic        due;
  assign cur     = ent.cursor;
  assign is_last = ({1'b0, cur} == ent.slices - 7'd1);
  assign sb      = is_last ? 11'(ent.size - (17'(ent.slices - 7'd1) << SbW))
                           : 11'(SliceBytes);
  assign due     = !ent.acked[cur] && ({1'b0, lrd} + 33'(ent.resend) < {1'b0, it.now_ms});

  assign in_ch.ready  = (st == S_IDLE) && !ovalid;
  assign out_ch.valid = ovalid;
  assign out_ch.data  = obuf;

  function automatic out_item_t mk(kind_t k, logic [15:0] id, logic [5:0] si,
                                   logic [6:0] ns, logic [10:0] b,
                                   logic [2:0] sl, logic lst);
    out_item_t o;
    o.kind = k; o.chunk_id = id; o.slice_index = si; o.num_slices = ns;
    o.slice_bytes = b; o.byte_offset = 16'(si) << SbW; o.slot = sl; o.last = lst;
    return o;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      st      <= S_IDLE;
      rate    <= RateReset;
      debt    <= '0;
      next_id <= '0;
      valid   <= '0;
      ovalid  <= 1'b0;
      swe     <= 1'b0;
      lwe     <= 1'b0;
      rstart  <= 1'b0;
    end else begin
      swe    <= 1'b0;
      lwe    <= 1'b0;
      rstart <= 1'b0;
      if (cfg_we) begin
        rate <= cfg_data;
        debt <= '0;
      end
      if (ovalid && out_ch.ready) ovalid <= 1'b0;
      unique case (st)
        S_IDLE: if (in_ch.valid && in_ch.ready) begin
          it <= in_ch.data;
          unique case (op_t'(in_ch.data.op))
            OP_SUBMIT: begin
              if (in_ch.data.chunk_size == '0 ||
                  in_ch.data.chunk_size > 17'(MaxSlices * SliceBytes) || !(&valid) == 1'b0)
              begin
                obuf   <= mk(K_REJECT, '0, '0, '0, '0, '0, 1'b1);
                ovalid <= 1'b1;
              end else begin
                s   <= free_s;
                idx <= '0;
                st  <= S_SUB_CLR;
              end
            end
            OP_ACK: begin
              s <= '0; n <= '0; st <= S_ACK_RD;
            end
            OP_TICK: begin
              rstart <= 1'b1; n <= '0; st <= S_TK_BUD;
            end
            default: ;
          endcase
        end
        S_SUB_CLR: begin
          lwe    <= 1'b1;
          lwaddr <= {s, idx[SliceW-1:0]};
          lwdata <= '0;
          if (idx == 7'(MaxSlices - 1)) begin
            swe    <= 1'b1;
            swaddr <= s;
            swdata <= '{chunk_id: next_id, size: it.chunk_size, slices: sub_slices,
                        cursor: '0, acked: '0, acked_count: '0,
                        resend: it.resend_ms, retries: 4'(MaxRetries)};
            valid[s] <= 1'b1;
            next_id  <= next_id + 16'd1;
            obuf   <= mk(K_ACCEPT, next_id, '0, sub_slices, '0, s, 1'b1);
            ovalid <= 1'b1;
            st     <= S_IDLE;
          end else idx <= idx + 7'd1;
        end
        // ack: scan slots in order, one read each
        S_ACK_RD: begin
          sraddr <= s;
          st     <= S_ACK_W;
        end
        S_ACK_W: st <= S_ACK_BITS;
        S_ACK_BITS: begin
          if (valid[s] && srd.chunk_id == it.ack_chunk_id &&
              srd.slices == it.ack_num_slices) begin
            ent <= srd;
            idx <= '0;
            st  <= S_ACK_END;
          end else if (s == SlotW'(MaxChunks - 1)) begin
            obuf <= mk(K_ACKDONE, it.ack_chunk_id, '0, '0, '0, '0, 1'b1);
            ovalid <= 1'b1;
            st <= S_IDLE;
          end else begin
            s  <= s + 1'b1;
            st <= S_ACK_RD;
          end
        end
        // one bit per cycle
        S_ACK_END: begin
          if (idx < ent.slices) begin
            if (!ent.acked[idx[SliceW-1:0]] && it.ack_bitmap[idx[SliceW-1:0]]) begin
              ent.acked[idx[SliceW-1:0]] <= 1'b1;
              ent.acked_count <= ent.acked_count + 7'd1;
            end
            idx <= idx + 7'd1;
          end else begin
            swe <= 1'b1; swaddr <= s; swdata <= ent;
            if (ent.acked_count == ent.slices) begin
              valid[s] <= 1'b0;
              obuf   <= mk(K_COMPLETE, it.ack_chunk_id, '0, ent.slices, '0, s, 1'b0);
              ovalid <= 1'b1;
              st_ret <= S_TK_END;
              st     <= S_EMIT;
              n      <= 7'd1;
            end else begin
              obuf <= mk(K_ACKDONE, it.ack_chunk_id, '0, '0, '0, '0, 1'b1);
              ovalid <= 1'b1;
              st <= S_IDLE;
            end
          end
        end
        S_EMIT: if (!ovalid) begin
          if (idx == 7'h7F) begin
            // give-up result follows its send beat
            obuf   <= mk(K_GIVEUP, ent.chunk_id, '0, ent.slices, '0, s, 1'b0);
            ovalid <= 1'b1;
            n      <= n + 7'd1;
            idx    <= '0;
          end else st <= st_ret;
        end
        S_TK_BUD: if (rdone) begin
          budget   <= rbudget;
          sent     <= ({6'd0, debt} > rbudget) ? 39'({6'd0, debt} - rbudget) : '0;
          progress <= 1'b1;
          st       <= S_TK_PASS;
        end
        S_TK_PASS: begin
          if (sent < budget && progress && n <= 7'(RunLimit)) begin
            progress <= 1'b0;
            s  <= '0;
            st <= S_TK_NEXT;
          end else begin
            debt <= (sent > 39'(DebtMax)) ? DebtMax : 33'(sent);
            st   <= S_TK_END;
          end
        end
        S_TK_NEXT: begin
          if (!valid[s]) begin
            if (s == SlotW'(MaxChunks - 1)) st <= S_TK_PASS;
            else s <= s + 1'b1;
          end else if (n > 7'(RunLimit)) st <= S_TK_PASS;
          else begin
            sraddr <= s;
            st <= S_TK_RD;
          end
        end
        S_TK_RD: st <= S_TK_W;
        S_TK_W: begin
          ent    <= srd;
          lraddr <= {s, srd.cursor};
          st     <= S_TK_LW;
        end
        // last-send word read in flight
        S_TK_LW: st <= S_TK_EVAL;
        S_TK_EVAL: if (!ovalid) begin
          begin
            slot_ent_t e;
            logic stop;
            e = ent;
            stop = 1'b0;
            e.cursor = (({1'b0, cur} + 7'd1) == ent.slices) ? '0 : cur + 6'd1;
            if (due) begin
              lwe <= 1'b1; lwaddr <= {s, cur}; lwdata <= it.now_ms;
              obuf <= mk(K_SEND, ent.chunk_id, cur, ent.slices, sb, s, 1'b0);
              ovalid <= 1'b1;
              n <= n + 7'd1;
              sent <= sent + 39'(sb);
              progress <= 1'b1;
              if (is_last) begin
                e.retries = ent.retries - 4'd1;
                if (e.retries == '0) begin
                  valid[s] <= 1'b0;
                  stop = 1'b1;
                end
              end
            end
            swe <= 1'b1; swaddr <= s; swdata <= e;
            if (stop) begin
              st     <= S_EMIT;
              st_ret <= S_TK_PASS;
              idx    <= 7'h7F;  // marks pending give-up
            end else if (due && (sent + 39'(sb) >= budget)) begin
              st <= S_TK_PASS;
            end else if (s == SlotW'(MaxChunks - 1)) st <= S_TK_PASS;
            else begin
              s <= s + 1'b1; st <= S_TK_NEXT;
            end
          end
        end
        S_TK_END: if (!ovalid) begin
          if (it.op == OP_ACK)
            obuf <= mk(K_ACKDONE, it.ack_chunk_id, '0, '0, '0, '0, 1'b1);
          else
            obuf <= mk(K_TICKDONE, '0, '0, '0, '0, '0, 1'b1);
          ovalid <= 1'b1;
          st <= S_IDLE;
        end
        default: st <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== rtl/chunk_slice_resend_sender_core.sv =====
// ----------------------------------------------------------------------------
// chunk_slice_resend_sender_core: selective-repeat slice sender
//
//   channel | dir | payload
//   in_ch   | in  | op, chunk_size, resend_ms, elapsed_ms, now_ms, ack fields
//   out_ch  | out | kind, chunk_id, slice_index, num_slices, bytes, offset, slot, last
//   cfg     | in  | cfg_we / cfg_data: bytes_per_second
//
// One item at a time. Submit clears the slot's 64 last-send words, one per
// cycle. Ack reads one descriptor per slot scanned, then walks the slice
// bits one at a time. Tick runs the budget math, then visits slots, each
// visit a read-modify-write of the slot memory.
// Reset clears valid bits, debt and id counter and loads the default rate; a
// stalled out_ch holds the sequencer before its next beat.
// ----------------------------------------------------------------------------
module chunk_slice_resend_sender_core import csrs_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [31:0] cfg_data,
  csrs_in_if.sink     in_ch,
  csrs_out_if.source  out_ch
);
  csrs_ctrl u_ctrl (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .in_ch(in_ch), .out_ch(out_ch)
  );
endmodule

// ===== rtl/csrs_chk.sv =====
// ----------------------------------------------------------------------------
// csrs_chk: port-level checks
// Watches results and handshakes on the top level.
// ----------------------------------------------------------------------------
module csrs_chk import csrs_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data)) else $error("out hold");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("accept while result pending");
  a_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.kind == K_REJECT || out_data.kind == K_TICKDONE)
    |-> out_data.last && out_data.chunk_id == '0) else $error("bad final");
  a_send: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.kind != K_SEND |-> out_data.slice_bytes == '0)
    else $error("bytes on non-send");
endmodule

bind chunk_slice_resend_sender_core csrs_chk u_chk (
  .clk(clk), .rst(rst), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data)
);
